[rtl/rs485de_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rs485de_pkg
// Types and constants shared by the RS-485 driver enable sequencer.
// ----------------------------------------------------------------------------
package rs485de_pkg;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_ASSERT  = 3'd1,
		ST_SETUP   = 3'd2,
		ST_DMA     = 3'd3,
		ST_WAITTC  = 3'd4,
		ST_HOLD    = 3'd5,
		ST_RELEASE = 3'd6,
		ST_ERROR   = 3'd7
	} seq_state_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_ABORT = 2'd2,
		CMD_TAKE  = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_SETUP   = 2'd0;
	localparam logic [1:0] REG_HOLD    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic [15:0] SETUP_RESET   = 16'd10;
	localparam logic [15:0] HOLD_RESET    = 16'd10;
	localparam logic [31:0] TIMEOUT_RESET = 32'd200000;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 64;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] now_us;
		logic [31:0] buffer_address;
		logic [15:0] transfer_length;
		logic        dma_start_ok;
		logic        uart_finished;
	} item_t;

	typedef struct packed {
		seq_state_t  state_code;
		logic        driver_enable;
		logic        dma_start_request;
		logic        dma_abort_request;
		logic [31:0] dma_address;
		logic [15:0] dma_length;
		logic        start_accepted;
		logic        done_taken;
		logic        busy_res;
	} result_t;

	typedef struct packed {
		logic        we;
		logic [1:0]  index;
		logic [31:0] wdata;
	} cfg_wr_t;

endpackage
`default_nettype wire

[rtl/rs485_driver_enable_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rs485_driver_enable_sequencer
// Steps the RS-485 driver enable around one DMA/UART transmission.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_*       in         command (tuser) and tick/start fields (tdata)
//  m_*       out        one result per command
//  cfg_*     in         setup, hold and timeout register writes
//
// One command per cycle sustained while m_* is not stalled; a result passes the
// input register, then the result register, before it is valid on m_*.
// Sequencer state is updated when a command moves into the result register.
// A stalled output holds its result; the input register still takes one more
// transaction, then s_tready drops until the output drains.
// Reset clears the sequencer to idle and loads register defaults.
module rs485_driver_enable_sequencer #(
	parameter int TIME_WIDTH = 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// now_us, buffer_address, transfer_length, dma_start_ok, uart_finished
	input  wire  [rs485de_pkg::IN_TDATA_W-1:0]   s_tdata,
	// cmd
	input  wire  [1:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// state_code, driver_enable, dma_start_request, dma_abort_request,
	// dma_address, dma_length, start_accepted, done_taken, busy_res
	output logic [rs485de_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  wire                                  cfg_we,
	input  wire  [1:0]                           cfg_index,
	input  wire  [31:0]                          cfg_wdata
);

	logic                  valid_s1;
	rs485de_pkg::item_t    item_s1;
	logic                  adv;
	rs485de_pkg::result_t  res;
	rs485de_pkg::result_t  res_q;
	rs485de_pkg::cfg_wr_t  cfg;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.cmd             <= rs485de_pkg::cmd_t'(s_tuser);
			item_s1.now_us          <= s_tdata[31:0];
			item_s1.buffer_address  <= s_tdata[63:32];
			item_s1.transfer_length <= s_tdata[79:64];
			item_s1.dma_start_ok    <= s_tdata[80];
			item_s1.uart_finished   <= s_tdata[81];
		end
	end

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;

	rs485de_seq #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.adv   (adv),
		.item  (item_s1),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tdata = {7'd0, res_q.busy_res, res_q.done_taken, res_q.start_accepted,
		res_q.dma_length, res_q.dma_address, res_q.dma_abort_request,
		res_q.dma_start_request, res_q.driver_enable, res_q.state_code};

endmodule
`default_nettype wire

[rtl/rs485de_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rs485de_seq
// Sequencer state, timing registers and per-item next-state logic.
// ----------------------------------------------------------------------------
module rs485de_seq #(
	parameter int TIME_WIDTH = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  rs485de_pkg::cfg_wr_t  cfg,
	input  wire                   adv,
	input  rs485de_pkg::item_t    item,
	output rs485de_pkg::result_t  res
);

	localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

	rs485de_pkg::seq_state_t state_q, state_d;
	logic [31:0]             addr_q, addr_d;
	logic [15:0]             len_q, len_d;
	logic [TIME_WIDTH-1:0]   phase_q, phase_d;
	logic [TIME_WIDTH-1:0]   xfer_q, xfer_d;
	logic                    done_q, done_d;
	logic                    en_q, en_d;
	logic [15:0]             setup_q;
	logic [15:0]             hold_q;
	logic [31:0]             timeout_q;

	logic [CW-1:0]           now_wide;
	logic [TIME_WIDTH-1:0]   now_t;
	logic [TIME_WIDTH-1:0]   xfer_diff, phase_diff;
	logic                    timed_out, setup_done, hold_done;
	logic                    start_pulse, abort_pulse, accepted, taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q   <= rs485de_pkg::SETUP_RESET;
			hold_q    <= rs485de_pkg::HOLD_RESET;
			timeout_q <= rs485de_pkg::TIMEOUT_RESET;
		end else if (cfg.we) begin
			case (cfg.index)
				rs485de_pkg::REG_SETUP:   setup_q   <= cfg.wdata[15:0];
				rs485de_pkg::REG_HOLD:    hold_q    <= cfg.wdata[15:0];
				rs485de_pkg::REG_TIMEOUT: timeout_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rs485de_pkg::ST_IDLE;
			addr_q  <= '0;
			len_q   <= '0;
			phase_q <= '0;
			xfer_q  <= '0;
			done_q  <= 1'b0;
			en_q    <= 1'b0;
		end else if (adv) begin
			state_q <= state_d;
			addr_q  <= addr_d;
			len_q   <= len_d;
			phase_q <= phase_d;
			xfer_q  <= xfer_d;
			done_q  <= done_d;
			en_q    <= en_d;
		end
	end

	// timestamps wrap modulo 2^TIME_WIDTH
	assign now_wide   = CW'(item.now_us);
	assign now_t      = now_wide[TIME_WIDTH-1:0];
	assign xfer_diff  = now_t - xfer_q;
	assign phase_diff = now_t - phase_q;
	assign timed_out  = CW'(xfer_diff) >= CW'(timeout_q);
	assign setup_done = CW'(phase_diff) >= CW'(setup_q);
	assign hold_done  = CW'(phase_diff) >= CW'(hold_q);

	always_comb begin
		state_d     = state_q;
		addr_d      = addr_q;
		len_d       = len_q;
		phase_d     = phase_q;
		xfer_d      = xfer_q;
		done_d      = done_q;
		en_d        = en_q;
		start_pulse = 1'b0;
		abort_pulse = 1'b0;
		accepted    = 1'b0;
		taken       = 1'b0;
		case (item.cmd)
			rs485de_pkg::CMD_START: begin
				if (state_q == rs485de_pkg::ST_IDLE && item.buffer_address != '0 &&
				    item.transfer_length != '0) begin
					addr_d   = item.buffer_address;
					len_d    = item.transfer_length;
					state_d  = rs485de_pkg::ST_ASSERT;
					done_d   = 1'b0;
					accepted = 1'b1;
				end
			end
			rs485de_pkg::CMD_ABORT: begin
				abort_pulse = 1'b1;
				en_d        = 1'b0;
				state_d     = rs485de_pkg::ST_IDLE;
			end
			rs485de_pkg::CMD_TAKE: begin
				taken  = done_q;
				done_d = 1'b0;
			end
			default: begin
				if ((state_q == rs485de_pkg::ST_DMA || state_q == rs485de_pkg::ST_WAITTC ||
				     state_q == rs485de_pkg::ST_HOLD) && timed_out) begin
					abort_pulse = 1'b1;
					en_d        = 1'b0;
					state_d     = rs485de_pkg::ST_ERROR;
				end else begin
					case (state_q)
						rs485de_pkg::ST_ASSERT: begin
							en_d    = 1'b1;
							phase_d = now_t;
							xfer_d  = now_t;
							state_d = rs485de_pkg::ST_SETUP;
						end
						rs485de_pkg::ST_SETUP: begin
							if (setup_done) begin
								start_pulse = 1'b1;
								if (item.dma_start_ok) begin
									state_d = rs485de_pkg::ST_DMA;
								end else begin
									en_d    = 1'b0;
									state_d = rs485de_pkg::ST_ERROR;
								end
							end
						end
						rs485de_pkg::ST_DMA: begin
							if (item.uart_finished) state_d = rs485de_pkg::ST_WAITTC;
						end
						rs485de_pkg::ST_WAITTC: begin
							if (item.uart_finished) begin
								phase_d = now_t;
								state_d = rs485de_pkg::ST_HOLD;
							end
						end
						rs485de_pkg::ST_HOLD: begin
							if (hold_done) state_d = rs485de_pkg::ST_RELEASE;
						end
						rs485de_pkg::ST_RELEASE: begin
							en_d    = 1'b0;
							done_d  = 1'b1;
							state_d = rs485de_pkg::ST_IDLE;
						end
						default: ;
					endcase
				end
			end
		endcase
	end

	always_comb begin
		res.state_code        = state_d;
		res.driver_enable     = en_d;
		res.dma_start_request = start_pulse;
		res.dma_abort_request = abort_pulse;
		res.dma_address       = addr_d;
		res.dma_length        = len_d;
		res.start_accepted    = accepted;
		res.done_taken        = taken;
		res.busy_res          = (state_d != rs485de_pkg::ST_IDLE);
	end

endmodule
`default_nettype wire

[rtl/rs485de_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rs485de_checker
// Port-level checks on the sequencer result stream.
// ----------------------------------------------------------------------------
module rs485de_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [63:0] m_tdata
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[56] == (m_tdata[2:0] != rs485de_pkg::ST_IDLE))
		else $error("busy flag disagrees with state");

	a_accept_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[54] |-> m_tdata[2:0] == rs485de_pkg::ST_ASSERT)
		else $error("accepted start not in assert state");

	a_abort_drops: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> !m_tdata[3] &&
			(m_tdata[2:0] == rs485de_pkg::ST_IDLE || m_tdata[2:0] == rs485de_pkg::ST_ERROR))
		else $error("abort left enable on");

	a_start_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |->
			m_tdata[2:0] == rs485de_pkg::ST_DMA || m_tdata[2:0] == rs485de_pkg::ST_ERROR)
		else $error("dma start request in wrong state");

endmodule

bind rs485_driver_enable_sequencer rs485de_checker u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

[tb/sv/tb_rs485_driver_enable_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rs485_driver_enable_sequencer
// Self-checking bench for the RS-485 driver enable sequencer. Commands go in
// on the s_* stream and results come out on m_*. A built-in sequencer model
// predicts every result and checks it field by field. The stimulus is a short
// directed run, then random transfers under several timing settings. Both
// stream sides stall at random, and once the output is held off long enough
// to back up the input.
// ----------------------------------------------------------------------------

class de_scoreboard;
	logic [15:0]             setup_us;
	logic [15:0]             hold_us;
	logic [31:0]             timeout_us;
	rs485de_pkg::seq_state_t seq_state;
	logic [31:0]             saved_addr;
	logic [15:0]             saved_len;
	logic [31:0]             phase_t0;
	logic [31:0]             xfer_t0;
	logic                    done_flag;
	logic                    enable_lvl;
	rs485de_pkg::result_t    expected_q[$];
	int unsigned             accepted;
	int unsigned             mismatches;

	function new();
		setup_us   = rs485de_pkg::SETUP_RESET;
		hold_us    = rs485de_pkg::HOLD_RESET;
		timeout_us = rs485de_pkg::TIMEOUT_RESET;
		seq_state  = rs485de_pkg::ST_IDLE;
		saved_addr = '0;
		saved_len  = '0;
		phase_t0   = '0;
		xfer_t0    = '0;
		done_flag  = 1'b0;
		enable_lvl = 1'b0;
		accepted   = 0;
		mismatches = 0;
	endfunction

	function void write_register(logic [1:0] idx, logic [31:0] value);
		case (idx)
			rs485de_pkg::REG_SETUP:   setup_us = value[15:0];
			rs485de_pkg::REG_HOLD:    hold_us = value[15:0];
			rs485de_pkg::REG_TIMEOUT: timeout_us = value;
			default: ;
		endcase
	endfunction

	// wrapping elapsed-time compare
	function bit elapsed(logic [31:0] now, logic [31:0] from, logic [31:0] span);
		logic [31:0] diff;
		diff = now - from;
		return diff >= span;
	endfunction

	function void note_item(rs485de_pkg::item_t it);
		rs485de_pkg::result_t r;
		r = '0;
		accepted++;
		case (it.cmd)
			rs485de_pkg::CMD_START: begin
				if (seq_state == rs485de_pkg::ST_IDLE && it.buffer_address != 0 &&
						it.transfer_length != 0) begin
					saved_addr = it.buffer_address;
					saved_len = it.transfer_length;
					seq_state = rs485de_pkg::ST_ASSERT;
					done_flag = 1'b0;
					r.start_accepted = 1'b1;
				end
			end
			rs485de_pkg::CMD_ABORT: begin
				r.dma_abort_request = 1'b1;
				enable_lvl = 1'b0;
				seq_state = rs485de_pkg::ST_IDLE;
			end
			rs485de_pkg::CMD_TAKE: begin
				r.done_taken = done_flag;
				done_flag = 1'b0;
			end
			default: begin
				// timeout wins over the phase step
				if (seq_state >= rs485de_pkg::ST_DMA && seq_state <= rs485de_pkg::ST_HOLD &&
						elapsed(it.now_us, xfer_t0, timeout_us)) begin
					r.dma_abort_request = 1'b1;
					enable_lvl = 1'b0;
					seq_state = rs485de_pkg::ST_ERROR;
				end else begin
					case (seq_state)
						rs485de_pkg::ST_ASSERT: begin
							enable_lvl = 1'b1;
							phase_t0 = it.now_us;
							xfer_t0 = it.now_us;
							seq_state = rs485de_pkg::ST_SETUP;
						end
						rs485de_pkg::ST_SETUP: begin
							if (elapsed(it.now_us, phase_t0, {16'd0, setup_us})) begin
								r.dma_start_request = 1'b1;
								if (it.dma_start_ok) begin
									seq_state = rs485de_pkg::ST_DMA;
								end else begin
									enable_lvl = 1'b0;
									seq_state = rs485de_pkg::ST_ERROR;
								end
							end
						end
						rs485de_pkg::ST_DMA: begin
							if (it.uart_finished)
								seq_state = rs485de_pkg::ST_WAITTC;
						end
						rs485de_pkg::ST_WAITTC: begin
							if (it.uart_finished) begin
								phase_t0 = it.now_us;
								seq_state = rs485de_pkg::ST_HOLD;
							end
						end
						rs485de_pkg::ST_HOLD: begin
							if (elapsed(it.now_us, phase_t0, {16'd0, hold_us}))
								seq_state = rs485de_pkg::ST_RELEASE;
						end
						rs485de_pkg::ST_RELEASE: begin
							enable_lvl = 1'b0;
							done_flag = 1'b1;
							seq_state = rs485de_pkg::ST_IDLE;
						end
						default: ;
					endcase
				end
			end
		endcase
		r.state_code = seq_state;
		r.driver_enable = enable_lvl;
		r.dma_address = saved_addr;
		r.dma_length = saved_len;
		r.busy_res = (seq_state != rs485de_pkg::ST_IDLE);
		expected_q.push_back(r);
	endfunction

	function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endfunction

	function void check_result(logic [rs485de_pkg::OUT_TDATA_W-1:0] raw);
		rs485de_pkg::result_t e;
		if (expected_q.size() == 0) begin
			mismatches++;
			$display("%0t: result with nothing expected, expected none, got %h", $time, raw);
			return;
		end
		e = expected_q.pop_front();
		compare_field("state_code", 32'(e.state_code), 32'(raw[2:0]));
		compare_field("driver_enable", 32'(e.driver_enable), 32'(raw[3]));
		compare_field("dma_start_request", 32'(e.dma_start_request), 32'(raw[4]));
		compare_field("dma_abort_request", 32'(e.dma_abort_request), 32'(raw[5]));
		compare_field("dma_address", e.dma_address, raw[37:6]);
		compare_field("dma_length", 32'(e.dma_length), 32'(raw[53:38]));
		compare_field("start_accepted", 32'(e.start_accepted), 32'(raw[54]));
		compare_field("done_taken", 32'(e.done_taken), 32'(raw[55]));
		compare_field("busy_res", 32'(e.busy_res), 32'(raw[56]));
		compare_field("padding", 32'd0, 32'(raw[63:57]));
	endfunction
endclass

module tb_rs485_driver_enable_sequencer;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASES = 7;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [rs485de_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic [1:0]                          s_tuser;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [rs485de_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                                cfg_we;
	logic [1:0]                          cfg_index;
	logic [31:0]                         cfg_wdata;

	de_scoreboard sb = new();
	logic [31:0]  clock_us;
	bit           calm;
	bit           squeeze_done;

	rs485_driver_enable_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// output side: random stalls, one long hold-off to back up the input
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (calm) begin
				m_tready <= 1'b1;
				@(negedge clk);
			end else if (!squeeze_done && sb.accepted >= 200) begin
				m_tready <= 1'b0;
				repeat (60) @(negedge clk);
				squeeze_done = 1'b1;
			end else if ($urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	// called and returns at a falling edge; s_tvalid stays high on return
	task automatic send_item(rs485de_pkg::cmd_t c, logic [31:0] now, logic [31:0] addr,
			logic [15:0] len, bit ok, bit uart);
		rs485de_pkg::item_t it;
		it.cmd = c;
		it.now_us = now;
		it.buffer_address = addr;
		it.transfer_length = len;
		it.dma_start_ok = ok;
		it.uart_finished = uart;
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {6'd0, it.uart_finished, it.dma_start_ok, it.transfer_length,
			it.buffer_address, it.now_us};
		do @(posedge clk); while (!s_tready);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic tick(logic [31:0] now, bit ok, bit uart);
		send_item(rs485de_pkg::CMD_TICK, now, $urandom, 16'($urandom_range(0, 65535)),
			ok, uart);
	endtask

	// drop valid and let every outstanding transaction drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_settings(logic [15:0] setup, logic [15:0] hold,
			logic [31:0] tmo);
		logic [1:0] idx;
		logic [31:0] val;
		for (int i = 0; i < 4; i++) begin
			case (i)
				0: begin idx = rs485de_pkg::REG_SETUP; val = {16'($urandom), setup}; end
				1: begin idx = rs485de_pkg::REG_HOLD; val = {16'($urandom), hold}; end
				2: begin idx = rs485de_pkg::REG_TIMEOUT; val = tmo; end
				default: begin idx = 2'd3; val = $urandom; end
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= val;
			sb.write_register(idx, val);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic directed_run();
		tick(32'hFFFF_FFFF, 1'b1, 1'b1);
		send_item(rs485de_pkg::CMD_TAKE, '0, '0, '0, 1'b0, 1'b0);
		send_item(rs485de_pkg::CMD_START, '0, 32'd0, 16'd5, 1'b0, 1'b0);
		send_item(rs485de_pkg::CMD_START, '0, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0);
		send_item(rs485de_pkg::CMD_START, '0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0);
		send_item(rs485de_pkg::CMD_START, '0, 32'h1234_5678, 16'd7, 1'b0, 1'b0);
		tick(32'hFFFF_FFF0, 1'b1, 1'b0);
		tick(32'hFFFF_FFF5, 1'b1, 1'b0);
		// setup ends across the wrap, DMA refuses
		tick(32'h0000_0004, 1'b0, 1'b0);
		tick(32'h0000_0100, 1'b1, 1'b1);
		send_item(rs485de_pkg::CMD_START, '0, 32'd9, 16'd9, 1'b0, 1'b0);
		send_item(rs485de_pkg::CMD_ABORT, '0, '0, '0, 1'b0, 1'b0);
		send_item(rs485de_pkg::CMD_START, '0, 32'd1, 16'd1, 1'b0, 1'b0);
		tick(32'd100, 1'b1, 1'b0);
		tick(32'd110, 1'b1, 1'b0);
		tick(32'd111, 1'b0, 1'b1);
		tick(32'd112, 1'b0, 1'b1);
		tick(32'd122, 1'b0, 1'b0);
		tick(32'd123, 1'b0, 1'b0);
		send_item(rs485de_pkg::CMD_TAKE, '0, '0, '0, 1'b0, 1'b0);
		send_item(rs485de_pkg::CMD_TAKE, '0, '0, '0, 1'b0, 1'b0);
		send_item(rs485de_pkg::CMD_START, '0, 32'd2, 16'd2, 1'b0, 1'b0);
		tick(32'd0, 1'b1, 1'b0);
		tick(32'd10, 1'b1, 1'b0);
		// overall timeout beats the uart step
		tick(32'd200000, 1'b1, 1'b1);
		send_item(rs485de_pkg::CMD_ABORT, '0, '0, '0, 1'b0, 1'b0);
	endtask

	task automatic run_transfer(int unsigned stride);
		int unsigned n;
		int unsigned pick;
		logic [31:0] addr;
		if (sb.seq_state != rs485de_pkg::ST_IDLE && $urandom_range(0, 4) != 0)
			send_item(rs485de_pkg::CMD_ABORT, $urandom, $urandom,
				16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		pick = $urandom_range(0, 9);
		addr = $urandom;
		if (addr == 0)
			addr = 32'd1;
		if (pick == 0)
			send_item(rs485de_pkg::CMD_START, $urandom, 32'd0,
				16'($urandom_range(0, 65535)), 1'b0, 1'b0);
		else if (pick == 1)
			send_item(rs485de_pkg::CMD_START, $urandom, addr, 16'd0, 1'b0, 1'b0);
		else
			send_item(rs485de_pkg::CMD_START, $urandom, addr, 16'($urandom_range(1, 65535)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		n = 0;
		while (sb.seq_state != rs485de_pkg::ST_IDLE && sb.seq_state != rs485de_pkg::ST_ERROR &&
				n < 80) begin
			n++;
			pick = $urandom_range(0, 19);
			if (pick < 17) begin
				clock_us = clock_us + $urandom_range(0, stride);
				tick(clock_us, $urandom_range(0, 9) != 0, $urandom_range(0, 2) == 0);
			end else begin
				send_item(rs485de_pkg::cmd_t'($urandom_range(0, 3)), $urandom, $urandom,
					16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end
		end
		if ($urandom_range(0, 1) == 1)
			send_item(rs485de_pkg::CMD_TAKE, $urandom, $urandom,
				16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		if (sb.seq_state == rs485de_pkg::ST_ERROR && $urandom_range(0, 2) == 0)
			tick(clock_us, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		logic [15:0] setup;
		logic [15:0] hold;
		logic [31:0] tmo;
		int unsigned stride;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = rs485de_pkg::CMD_TICK;
		cfg_we = 1'b0;
		cfg_index = rs485de_pkg::REG_SETUP;
		cfg_wdata = '0;
		calm = 1'b0;
		squeeze_done = 1'b0;
		clock_us = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_run();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					setup = rs485de_pkg::SETUP_RESET;
					hold = rs485de_pkg::HOLD_RESET;
					tmo = rs485de_pkg::TIMEOUT_RESET;
				end
				1: begin setup = 16'd0; hold = 16'd0; tmo = 32'd0; end
				2: begin setup = 16'hFFFF; hold = 16'hFFFF; tmo = 32'hFFFF_FFFF; end
				default: begin
					setup = 16'($urandom_range(0, 300));
					hold = 16'($urandom_range(0, 300));
					tmo = $urandom_range(50, 3000);
				end
			endcase
			if (p > 0) begin
				settle();
				write_settings(setup, hold, tmo);
			end
			stride = ((setup > hold) ? setup : hold) / 5 + 2;
			calm = (p == PHASES - 1);
			clock_us = (p == 3) ? 32'hFFFF_F000 : $urandom;
			while (sb.accepted < 25 + 70 * (p + 1))
				run_transfer(stride);
		end

		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/rs485de_pkg.sv
rtl/rs485de_seq.sv
rtl/rs485_driver_enable_sequencer.sv
rtl/rs485de_checker.sv
tb/sv/tb_rs485_driver_enable_sequencer.sv
